### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is high
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every rising edge, off while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/xrb_pkg.sv
// types, constants and the generator step for the bounded random block
package xrb_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CountWidth = 6;

   localparam logic [WordWidth-1:0] DefaultSeed = 32'h6d2b79f5;
   localparam logic [WordWidth-1:0] Low29Mask   = 32'h1fffffff;
   localparam int unsigned ShiftA = 13;
   localparam int unsigned ShiftB = 17;
   localparam int unsigned ShiftC = 5;

   localparam logic [1:0] ModeRaw    = 2'd0;
   localparam logic [1:0] ModeMasked = 2'd1;
   localparam logic [1:0] ModeBelow  = 2'd2;
   localparam logic [1:0] ModeIdle   = 2'd3;

   localparam logic StatusOk     = 1'b0;
   localparam logic StatusBounds = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_THRESH,
      ST_REJECT,
      ST_MODULO,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

   function automatic logic [WordWidth-1:0] seed_fix(input logic [WordWidth-1:0] x);
      return (x == '0) ? DefaultSeed : x;
   endfunction

   function automatic logic [WordWidth-1:0] xs_next(input logic [WordWidth-1:0] s);
      logic [WordWidth-1:0] x;
      x = seed_fix(s);
      x = x ^ (x << ShiftA);
      x = x ^ (x >> ShiftB);
      x = x ^ (x << ShiftC);
      return seed_fix(x);
   endfunction

endpackage

### hw/rtl/xrb_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module xrb_rem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [xrb_pkg::WordWidth-1:0] dividend,
   input  logic [xrb_pkg::WordWidth-1:0] divisor,
   output xrb_pkg::rem_status_type       status,
   output logic [xrb_pkg::WordWidth-1:0] remainder
);
   import xrb_pkg::*;

   logic [WordWidth-1:0]  rem_ff, rem_in;
   logic [WordWidth-1:0]  dvd_ff, dvd_in;
   logic [WordWidth-1:0]  dvs_ff, dvs_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [WordWidth:0]    trial;
   logic [WordWidth:0]    diff;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, dvd_ff[WordWidth-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         dvd_in   = dividend;
         dvs_in   = divisor;
         count_in = CountWidth'(WordWidth);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // no borrow means trial >= divisor
         rem_in   = diff[WordWidth] ? trial[WordWidth-1:0] : diff[WordWidth-1:0];
         dvd_in   = {dvd_ff[WordWidth-2:0], 1'b0};
         count_in = count_ff - CountWidth'(1);
         if (count_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

### hw/rtl/xorshift_random_below.sv
// top level: xorshift32 generator with raw, masked and bounded request modes
//
// requests arrive on the req_ stream: req_tuser carries the mode, req_tdata the
// limit. one response word per request leaves on the rsp_ stream: rsp_tdata
// carries the value, rsp_tuser the status (1 when mode 2 is asked with limit 0).
// a request is taken only while the block is idle; it works on one request
// at a time.
// the short modes (0, 1, 3) and the bounds error go from accept straight to
// the done state. mode 2 runs the bit-serial remainder unit twice, once for
// the rejection threshold and once for the final reduction, with one draw
// per cycle in between until a draw clears the threshold.
// the next request is accepted while a finished response still waits; its
// result is held until the output register frees up, so a stalled receiver
// stalls the block after at most one further request.
// reset clears the generator state to zero, which acts as the default seed,
// and drops any pending response.
module xorshift_random_below (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [xrb_pkg::WordWidth-1:0] req_tdata,   // [31:0] limit
   input  logic [7:0]                    req_tuser,   // [1:0] mode, [7:2] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [xrb_pkg::WordWidth-1:0] rsp_tdata,   // [31:0] value
   output logic [7:0]                    rsp_tuser    // [0] status, [7:1] zero
);
   import xrb_pkg::*;

   state_type            state_ff, state_in;
   logic [WordWidth-1:0] gen_ff, gen_in;
   logic [WordWidth-1:0] limit_ff, limit_in;
   logic [WordWidth-1:0] thresh_ff, thresh_in;
   logic [WordWidth-1:0] res_value_ff, res_value_in;
   logic                 res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WordWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic [WordWidth-1:0] draw_word;
   logic [WordWidth-1:0] req_limit;
   logic [1:0]           req_mode;
   logic                 req_accept;
   logic                 out_free;

   logic                 rem_start;
   logic [WordWidth-1:0] rem_dividend;
   logic [WordWidth-1:0] rem_divisor;
   rem_status_type       rem_status;
   logic [WordWidth-1:0] rem_result;

   assign req_limit  = req_tdata[WordWidth-1:0];
   assign req_mode   = req_tuser[1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign draw_word  = xs_next(gen_ff);

   xrb_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .status    (rem_status),
      .remainder (rem_result)
   );

   always_comb begin
      state_in      = state_ff;
      gen_in        = gen_ff;
      limit_in      = limit_ff;
      thresh_in     = thresh_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rem_start     = 1'b0;
      rem_dividend  = draw_word;
      rem_divisor   = limit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               limit_in      = req_limit;
               res_value_in  = '0;
               res_status_in = StatusOk;
               state_in      = ST_DONE;
               case (req_mode)
                  ModeRaw: begin
                     gen_in       = draw_word;
                     res_value_in = draw_word;
                  end
                  ModeMasked: begin
                     gen_in       = draw_word;
                     res_value_in = draw_word & Low29Mask;
                  end
                  ModeBelow: begin
                     if (req_limit == '0) begin
                        res_status_in = StatusBounds;
                     end else begin
                        // threshold = (2^32 - limit) mod limit
                        rem_start    = 1'b1;
                        rem_dividend = '0 - req_limit;
                        rem_divisor  = req_limit;
                        state_in     = ST_THRESH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_THRESH: begin
            if (rem_status.done) begin
               thresh_in = rem_result;
               state_in  = ST_REJECT;
            end
         end
         ST_REJECT: begin
            // one draw per cycle until a draw clears the threshold
            gen_in = draw_word;
            if (draw_word >= thresh_ff) begin
               rem_start = 1'b1;
               state_in  = ST_MODULO;
            end
         end
         ST_MODULO: begin
            if (rem_status.done) begin
               res_value_in = rem_result;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff      <= limit_in;
      thresh_ff     <= thresh_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {7'd0, rsp_status_ff};

`include "assert_macros.svh"

   // the remainder unit only runs while a bounded request is in work
   `ASSERT_IMPL(a_rem_busy_state, clock, reset, rem_status.busy,
      state_ff == ST_THRESH || state_ff == ST_MODULO, "remainder unit busy outside mode 2")

   // a finished remainder is only reported to a state that waits for it
   `ASSERT_IMPL(a_rem_done_state, clock, reset, rem_status.done,
      state_ff == ST_THRESH || state_ff == ST_MODULO, "remainder done with nobody waiting")

   // a bounds error always carries a zero value
   `ASSERT_IMPL(a_bounds_zero, clock, reset, rsp_valid_ff && rsp_status_ff,
      rsp_value_ff == '0, "bounds error with nonzero value")

   // the rejection threshold is always below the limit
   `ASSERT_IMPL(a_mod_below, clock, reset, state_ff == ST_REJECT,
      thresh_ff < limit_ff, "threshold not below limit")

endmodule
